// ----- rtl/fxalu_pkg.sv -----
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types, constants and saturation helper of the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 8;

  localparam int ProdW     = 2 * DATA_WIDTH;         // full product width
  localparam int DivW      = DATA_WIDTH + FRAC_BITS; // dividend/quotient width
  localparam int DivSteps  = DivW;                   // one quotient bit per stage
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [DATA_WIDTH-1:0] mag_t;
  typedef logic        [ProdW:0]        wmag_t;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_CMP      = 4'd4,
    CMD_MIN      = 4'd5,
    CMD_MAX      = 4'd6,
    CMD_INC      = 4'd7,
    CMD_DEC      = 4'd8,
    CMD_TO_INT   = 4'd9,
    CMD_FROM_INT = 4'd10
  } cmd_e;

  // work class handed from the front to the back
  typedef enum logic [1:0] {
    OPC_SIMPLE = 2'd0,
    OPC_MUL    = 2'd1,
    OPC_DIV    = 2'd2
  } opc_e;

  typedef struct packed {
    opc_e  opc;
    logic  neg;
    data_t res;
    logic  ovf;
    logic  dz;
    logic  lt;
    logic  eq;
    logic  gt;
    mag_t  ma;
    mag_t  mb;
  } item_t;

  typedef struct packed {
    logic  ovf;
    data_t res;
  } sat_t;

  localparam data_t MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam wmag_t PosLim = {{(ProdW-DATA_WIDTH+2){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam wmag_t NegLim = {{(ProdW-DATA_WIDTH+1){1'b0}}, 1'b1,
                              {(DATA_WIDTH-1){1'b0}}};
  localparam wmag_t MulHalf = wmag_t'(2**FRAC_BITS) >> 1;

  // sign + magnitude -> saturated two's complement
  function automatic sat_t sat_pack(input logic neg, input wmag_t mag);
    sat_t r;
    r.ovf = 1'b0;
    if (!neg) begin
      if (mag > PosLim) begin
        r.ovf = 1'b1;
        r.res = MaxVal;
      end else begin
        r.res = data_t'(mag[DATA_WIDTH-1:0]);
      end
    end else begin
      if (mag > NegLim) begin
        r.ovf = 1'b1;
        r.res = MinVal;
      end else begin
        r.res = data_t'({DATA_WIDTH{1'b0}} - mag[DATA_WIDTH-1:0]);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/fxalu_front.sv -----
// ----------------------------------------------------------------------------
// fxalu_front
// Classifies a command, computes flags and every result but multiply and divide.
// ----------------------------------------------------------------------------
module fxalu_front
  import fxalu_pkg::*;
(
  input  logic [3:0] cmd_i,
  input  data_t      operand_a_i,
  input  data_t      operand_b_i,
  output item_t      item_o
);

  function automatic sat_t add_sat(input data_t x, input data_t y, input logic sub);
    sat_t  r;
    data_t s;
    logic  same;
    s     = sub ? data_t'(x - y) : data_t'(x + y);
    same  = sub ? (x[DATA_WIDTH-1] != y[DATA_WIDTH-1])
                : (x[DATA_WIDTH-1] == y[DATA_WIDTH-1]);
    r.ovf = same && (s[DATA_WIDTH-1] != x[DATA_WIDTH-1]);
    r.res = r.ovf ? (x[DATA_WIDTH-1] ? MinVal : MaxVal) : s;
    return r;
  endfunction

  localparam data_t One    = data_t'(1);
  localparam mag_t  PosInt = mag_t'(MaxVal) >> FRAC_BITS;
  localparam mag_t  NegInt = mag_t'(MinVal) >> FRAC_BITS;

  logic na, nb;
  mag_t ma, mb;
  sat_t sr;

  assign na = operand_a_i[DATA_WIDTH-1];
  assign nb = operand_b_i[DATA_WIDTH-1];
  assign ma = na ? mag_t'({DATA_WIDTH{1'b0}} - operand_a_i) : mag_t'(operand_a_i);
  assign mb = nb ? mag_t'({DATA_WIDTH{1'b0}} - operand_b_i) : mag_t'(operand_b_i);

  always_comb begin
    item_o     = '0;
    item_o.lt  = operand_a_i < operand_b_i;
    item_o.eq  = operand_a_i == operand_b_i;
    item_o.gt  = operand_a_i > operand_b_i;
    item_o.ma  = ma;
    item_o.mb  = mb;
    item_o.neg = na ^ nb;
    item_o.opc = OPC_SIMPLE;
    sr         = '0;
    unique case (cmd_i)
      CMD_ADD:    sr = add_sat(operand_a_i, operand_b_i, 1'b0);
      CMD_SUB:    sr = add_sat(operand_a_i, operand_b_i, 1'b1);
      CMD_MUL:    item_o.opc = OPC_MUL;
      CMD_DIV: begin
        if (operand_b_i == '0) item_o.dz = 1'b1;
        else                   item_o.opc = OPC_DIV;
      end
      CMD_MIN:    sr.res = item_o.lt ? operand_a_i : operand_b_i;
      CMD_MAX:    sr.res = item_o.gt ? operand_a_i : operand_b_i;
      CMD_INC:    sr = add_sat(operand_a_i, One, 1'b0);
      CMD_DEC:    sr = add_sat(operand_a_i, One, 1'b1);
      CMD_TO_INT: sr.res = operand_a_i >>> FRAC_BITS;
      CMD_FROM_INT: begin
        if (ma > (na ? NegInt : PosInt)) begin
          sr.ovf = 1'b1;
          sr.res = na ? MinVal : MaxVal;
        end else begin
          sr.res = operand_a_i <<< FRAC_BITS;
        end
      end
      default:    sr = '0; // compare and unused codes: result zero
    endcase
    item_o.res = sr.res;
    item_o.ovf = sr.ovf;
  end

endmodule

// ----- rtl/fxalu_fifo.sv -----
// ----------------------------------------------------------------------------
// fxalu_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module fxalu_fifo
  import fxalu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t             mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == (PtrW+1)'(FifoDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

// ----- rtl/fxalu_back.sv -----
// ----------------------------------------------------------------------------
// fxalu_back
// Multiply stage, radix-2 divide pipeline, rounding/saturation and output reg.
// ----------------------------------------------------------------------------
module fxalu_back
  import fxalu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output data_t result_o,
  output logic  is_less_o,
  output logic  is_equal_o,
  output logic  is_greater_o,
  output logic  div_by_zero_o,
  output logic  overflow_o
);

  typedef struct packed {
    opc_e                 opc;
    logic                 neg;
    data_t                res;
    logic                 ovf;
    logic                 dz;
    logic                 lt;
    logic                 eq;
    logic                 gt;
    logic [ProdW-1:0]     wide;  // product, or dividend shifting out msb first
    logic [DATA_WIDTH:0]  rem;
    logic [DivW-1:0]      quo;
    mag_t                 den;
  } stg_t;

  stg_t                 st_q [DivSteps+1];
  stg_t                 st_d [DivSteps+1];
  logic [DivSteps:0]    vld_q;
  logic                 adv;
  logic                 out_valid_q;
  stg_t                 fin;
  sat_t                 sp;
  logic                 rnd;

  // whole back end moves together
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv;

  always_comb begin
    logic [DATA_WIDTH:0] rs;
    rs            = '0;
    st_d[0].opc   = item_i.opc;
    st_d[0].neg   = item_i.neg;
    st_d[0].res   = item_i.res;
    st_d[0].ovf   = item_i.ovf;
    st_d[0].dz    = item_i.dz;
    st_d[0].lt    = item_i.lt;
    st_d[0].eq    = item_i.eq;
    st_d[0].gt    = item_i.gt;
    st_d[0].wide  = (item_i.opc == OPC_MUL)
                  ? ProdW'(item_i.ma) * ProdW'(item_i.mb)
                  : ProdW'(item_i.ma) << FRAC_BITS;
    st_d[0].rem   = '0;
    st_d[0].quo   = '0;
    st_d[0].den   = item_i.mb;
    for (int k = 1; k <= DivSteps; k++) begin
      st_d[k] = st_q[k-1];
      if (st_q[k-1].opc == OPC_DIV) begin
        rs = {st_q[k-1].rem[DATA_WIDTH-1:0], st_q[k-1].wide[DivW-1]};
        st_d[k].wide = st_q[k-1].wide << 1;
        if (rs >= {1'b0, st_q[k-1].den}) begin
          st_d[k].rem = rs - {1'b0, st_q[k-1].den};
          st_d[k].quo = {st_q[k-1].quo[DivW-2:0], 1'b1};
        end else begin
          st_d[k].rem = rs;
          st_d[k].quo = {st_q[k-1].quo[DivW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DivSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= DivSteps; k++) st_q[k] <= st_d[k];
    end
  end

  // final rounding and saturation
  assign fin = st_q[DivSteps];
  assign rnd = {fin.rem, 1'b0} >= {2'b00, fin.den};

  always_comb begin
    unique case (fin.opc)
      OPC_MUL: sp = sat_pack(fin.neg, ({1'b0, fin.wide} + MulHalf) >> FRAC_BITS);
      OPC_DIV: sp = sat_pack(fin.neg, wmag_t'(fin.quo) + wmag_t'(rnd));
      default: begin
        sp.res = fin.res;
        sp.ovf = fin.ovf;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_o      <= sp.res;
      overflow_o    <= sp.ovf;
      div_by_zero_o <= fin.dz;
      is_less_o     <= fin.lt;
      is_equal_o    <= fin.eq;
      is_greater_o  <= fin.gt;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/fixed_point_q24_8_alu.sv -----
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed Q24.8 ALU: add, sub, mul, div, compare, min, max, inc, dec, convert.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid_i/in_ready_o | cmd_i, operand_a_i, operand_b_i
//  out      | out_valid_o/out_ready_i| result_o, is_less_o, is_equal_o,
//           |                       | is_greater_o, div_by_zero_o, overflow_o
//
//  One beat per cycle sustained while out_ready_i stays high. Every beat
//  passes from the queue through the radix-2 divide pipeline, one
//  quotient bit per stage, which all commands traverse so results stay
//  in order.
//  Reset clears the queue and all valid bits; no clearing pass.
//  A stalled output freezes the back pipeline; the 4-entry queue keeps
//  in_ready_o high until it fills.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu
  import fxalu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] cmd_i,
  input  data_t      operand_a_i,
  input  data_t      operand_b_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output data_t      result_o,
  output logic       is_less_o,
  output logic       is_equal_o,
  output logic       is_greater_o,
  output logic       div_by_zero_o,
  output logic       overflow_o
);

  item_t f_item, q_item;
  logic  q_full, q_valid, q_pop;

  // front: decode, flags, cheap results
  fxalu_front u_front (
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .item_o      (f_item)
  );

  fxalu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  assign in_ready_o = !q_full;

  // back: multiply, divide, round, saturate
  fxalu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_o      (result_o),
    .is_less_o     (is_less_o),
    .is_equal_o    (is_equal_o),
    .is_greater_o  (is_greater_o),
    .div_by_zero_o (div_by_zero_o),
    .overflow_o    (overflow_o)
  );

endmodule

// ----- rtl/fxalu_checker.sv -----
// ----------------------------------------------------------------------------
// fxalu_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fxalu_checker
  import fxalu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_o,
  input  logic [3:0] cmd_i,
  input  data_t      operand_a_i,
  input  data_t      operand_b_i,
  input  logic       out_valid_o,
  input  logic       out_ready_i,
  input  data_t      result_o,
  input  logic       is_less_o,
  input  logic       is_equal_o,
  input  logic       is_greater_o,
  input  logic       div_by_zero_o,
  input  logic       overflow_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_o) && $stable(overflow_o))
    else $error("output payload changed while stalled");

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({is_less_o, is_equal_o, is_greater_o}))
    else $error("compare flags not one-hot");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_by_zero_o |-> result_o == '0 && !overflow_o)
    else $error("divide by zero with nonzero result");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> result_o == MaxVal || result_o == MinVal)
    else $error("overflow without saturated result");

endmodule

bind fixed_point_q24_8_alu fxalu_checker u_fxalu_checker (.*);
